// ----- design/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
package ple_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned HIN_W  = 16;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [HIN_W-1:0] handle;
  } ple_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [HIN_W-1:0] read_handle;
    logic [CNT_W-1:0] entry_count;
  } ple_res_t;

endpackage

// ----- design/ple_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ple_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ple_ctrl.sv -----
// Sequencer and shared index unit that shift list entries through the RAM.
module ple_ctrl #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  ple_pkg::ple_req_t        req_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output ple_pkg::ple_res_t        res_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [HANDLE_BITS-1:0]   mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  logic [HANDLE_BITS-1:0]   mem_rdata_i
);
  import ple_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_WR     = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          tgt_q, tgt_d;
  logic [OP_W-1:0]        op_q, op_d;
  logic [ST_W-1:0]        st_q, st_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d;
  logic [HANDLE_BITS-1:0] rd_q, rd_d;

  logic [PW-1:0]   posx, cntx;
  logic [AW-1:0]   ins_pos;
  logic [AW-1:0]   step;
  logic            more;

  assign posx    = PW'(req_i.position);
  assign cntx    = PW'(cnt_q);
  assign ins_pos = (posx > cntx) ? AW'(cnt_q) : AW'(posx);

  // Shared index unit: insert walks down, remove walks up.
  assign step = (op_q == OP_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
  assign more = (op_q == OP_INSERT) ? (step > tgt_q) : (step < tgt_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    tgt_d   = tgt_q;
    op_d    = op_q;
    st_d    = st_q;
    hdl_d   = hdl_q;
    rd_d    = rd_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = (state_q == S_RD) ? step : AW'(posx);

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d  = req_i.operation;
          hdl_d = HANDLE_BITS'(req_i.handle);
          st_d  = ST_DONE;
          rd_d  = '0;
          unique case (req_i.operation)
            OP_INSERT: begin
              if (cnt_q == CW'(DEPTH)) begin
                st_d    = ST_FULL;
                state_d = S_DONE;
              end else begin
                idx_d   = AW'(cnt_q);
                tgt_d   = ins_pos;
                state_d = (posx < cntx) ? S_RD : S_PUT;
              end
            end
            OP_REMOVE: begin
              if (posx >= cntx) begin
                st_d    = ST_RANGE;
                state_d = S_DONE;
              end else begin
                idx_d = AW'(posx);
                tgt_d = AW'(cnt_q - 1'b1);
                if ((PW + 1)'(posx) + 1'b1 < (PW + 1)'(cntx)) begin
                  state_d = S_RD;
                end else begin
                  cnt_d   = cnt_q - 1'b1;
                  state_d = S_DONE;
                end
              end
            end
            OP_READ: begin
              if (posx >= cntx) begin
                st_d    = ST_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_RDWAIT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        // Move the neighbor one place and advance.
        mem_we_o = 1'b1;
        idx_d    = step;
        if (more) begin
          state_d = S_RD;
        end else if (op_q == OP_INSERT) begin
          state_d = S_PUT;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end
      end
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q;
        mem_wdata_o = hdl_q;
        cnt_d       = cnt_q + 1'b1;
        state_d     = S_DONE;
      end
      S_RDWAIT: begin
        rd_d    = mem_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    tgt_q <= tgt_d;
    op_q  <= op_d;
    st_q  <= st_d;
    hdl_q <= hdl_d;
    rd_q  <= rd_d;
  end

  assign idle_o            = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = st_q;
  assign res_o.read_handle = HIN_W'(rd_q);
  assign res_o.entry_count = CNT_W'(cnt_q);

endmodule

// ----- design/positional_list_engine.sv -----
// Path to the output register: a read waits on the registered RAM read; insert moves
// entries up, then writes the handle; remove moves entries down; rejected and unused
// requests go straight to the result. Each move is one RAM read state and one RAM write state.
// Throughput: one request at a time; the next is taken the cycle after the result
// enters the output register, and the result waits while that register is stalled.
// Reset: asynchronous; clears the entry count, control and output valid; RAM is not cleared.
module positional_list_engine #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ple_pkg::OP_W-1:0]    operation_i,
  input  logic [ple_pkg::POS_W-1:0]   position_i,
  input  logic [ple_pkg::HIN_W-1:0]   handle_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ple_pkg::ST_W-1:0]    status_o,
  output logic [ple_pkg::HIN_W-1:0]   read_handle_o,
  output logic [ple_pkg::CNT_W-1:0]   entry_count_o
);
  import ple_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  ple_req_t               req;
  ple_res_t               res;
  ple_res_t               out_q;
  logic                   out_valid_q;
  logic                   idle;
  logic                   res_valid;
  logic                   slot_free;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [HANDLE_BITS-1:0] mem_wdata, mem_rdata;

  assign req.operation = operation_i;
  assign req.position  = position_i;
  assign req.handle    = handle_i;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !idle;

  ple_ctrl #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (req),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (slot_free),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ple_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign read_handle_o = out_q.read_handle;
  assign entry_count_o = out_q.entry_count;

endmodule

// ----- design/ple_checker.sv -----
// Port-level checks for the positional list engine, bound to the top level.
module ple_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [ple_pkg::ST_W-1:0]  status_o,
  input logic [ple_pkg::HIN_W-1:0] read_handle_o,
  input logic [ple_pkg::CNT_W-1:0] entry_count_o
);
  import ple_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(read_handle_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  // A taken request keeps the engine busy for at least the next cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted back to back");

  // Failed requests never return a handle.
  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_RANGE || status_o == ST_FULL)
      |-> read_handle_o == '0)
    else $error("handle on failed request");

  // A full rejection reports a full count.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_count_o == CNT_W'(DEPTH))
    else $error("full status with wrong count");

endmodule

bind positional_list_engine ple_checker #(
  .DEPTH (DEPTH)
) u_ple_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .read_handle_o (read_handle_o),
  .entry_count_o (entry_count_o)
);

// ----- bench/positional_list_engine_tb.sv -----
// Self-checking testbench for the positional list engine: directed and random bursty requests, stalled results.
`timescale 1ns / 100ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned MAX_REPORTS  = 60;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    ple_req_t req;
    bit       wait_idle;
  } list_request_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_ALTERNATE} stall_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [OP_W-1:0]  operation_i = '0;
  logic [POS_W-1:0] position_i = '0;
  logic [HIN_W-1:0] handle_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ST_W-1:0]  status_o;
  logic [HIN_W-1:0] read_handle_o;
  logic [CNT_W-1:0] entry_count_o;

  list_request_t pending_requests[$];
  ple_res_t      expected_results[$];
  logic [HIN_W-1:0] list_store[$];
  list_request_t on_wire;
  int unsigned   gen_count = 0;
  int unsigned   errors = 0;
  int unsigned   gap_left = 0;
  int unsigned   burst_left = 1;
  stall_mode_e   stall_mode = STALL_NONE;
  int unsigned   mode_left = 0;
  int unsigned   run_left = 0;

  positional_list_engine #(
    .DEPTH       (LIST_DEPTH),
    .HANDLE_BITS (16)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .handle_i      (handle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_handle_o (read_handle_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Apply one accepted request to the shadow list and queue the result it yields.
  function automatic void predict_list_request(input ple_req_t r);
    ple_res_t    res;
    int unsigned pos;
    pos = 32'(r.position);
    res.status = ST_DONE;
    res.read_handle = '0;
    case (r.operation)
      OP_INSERT: begin
        if (list_store.size() >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (pos > list_store.size()) pos = list_store.size();
          list_store.insert(pos, r.handle);
        end
      end
      OP_REMOVE: begin
        if (pos >= list_store.size()) res.status = ST_RANGE;
        else list_store.delete(pos);
      end
      OP_READ: begin
        if (pos >= list_store.size()) res.status = ST_RANGE;
        else res.read_handle = list_store[pos];
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(list_store.size());
    expected_results.push_back(res);
  endfunction

  task automatic add_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [HIN_W-1:0] h, input bit wait_idle);
    list_request_t item;
    item.req.operation = op;
    item.req.position = pos;
    item.req.handle = h;
    item.wait_idle = wait_idle;
    pending_requests.push_back(item);
    if (op == OP_INSERT && gen_count < LIST_DEPTH) gen_count++;
    else if (op == OP_REMOVE && pos < gen_count) gen_count--;
  endtask

  function automatic logic [OP_W-1:0] pick_operation(input int unsigned ins_pct,
                                                     input int unsigned rem_pct);
    int unsigned roll;
    if ($urandom_range(0, 99) < 3) return OP_UNUSED;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return OP_INSERT;
    if (roll < ins_pct + rem_pct) return OP_REMOVE;
    return OP_READ;
  endfunction

  // Mostly valid positions, with boundaries and wild values mixed in.
  function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
    int unsigned lim;
    int unsigned roll;
    lim = (op == OP_INSERT || gen_count == 0) ? gen_count : gen_count - 1;
    roll = $urandom_range(0, 19);
    if (roll < 14) return POS_W'($urandom_range(0, lim));
    if (roll < 16) return POS_W'(lim);
    if (roll < 17) return '0;
    if (roll < 18) return POS_W'(gen_count);
    return POS_W'($urandom_range(0, 127));
  endfunction

  task automatic add_random(input int unsigned ins_pct, input int unsigned rem_pct,
                            input bit wait_idle);
    logic [OP_W-1:0] op;
    op = pick_operation(ins_pct, rem_pct);
    add_request(op, pick_position(op), HIN_W'($urandom_range(0, 16'hFFFF)), wait_idle);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result();
    ple_res_t exp_r;
    if (expected_results.size() == 0) begin
      if (errors < MAX_REPORTS)
        $display("%0t: unexpected result, expected none actual status=%0d handle=%0d count=%0d",
                 $time, status_o, read_handle_o, entry_count_o);
      errors++;
    end else begin
      exp_r = expected_results.pop_front();
      compare_field("status", 32'(exp_r.status), 32'(status_o));
      compare_field("read_handle", 32'(exp_r.read_handle), 32'(read_handle_o));
      compare_field("entry_count", 32'(exp_r.entry_count), 32'(entry_count_o));
    end
  endtask

  // Request driver: bursts with random gaps, holds the payload while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= '0;
      position_i <= '0;
      handle_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_list_request(on_wire.req);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0 &&
                     (!pending_requests[0].wait_idle || expected_results.size() == 0)) begin
          on_wire = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= on_wire.req.operation;
          position_i <= on_wire.req.position;
          handle_i <= on_wire.req.handle;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = $urandom_range(0, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each taken result and stalls on a changing pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_COIN: out_stall_i <= ($urandom_range(0, 2) == 0);
        STALL_RUNS: begin
          if (run_left > 0) begin
            run_left--;
          end else begin
            run_left = $urandom_range(0, 12);
            out_stall_i <= !out_stall_i;
          end
        end
        default: out_stall_i <= !out_stall_i;
      endcase
    end
  end

  initial begin
    int unsigned random_count;
    int unsigned phase_len;
    int unsigned kind;

    // Empty list: out of range, then appends, front and middle inserts, and reads.
    add_request(OP_READ,   7'd0,   16'h0000, 1'b0);
    add_request(OP_REMOVE, 7'd0,   16'hFFFF, 1'b0);
    add_request(OP_UNUSED, 7'd0,   16'h0000, 1'b0);
    add_request(OP_INSERT, 7'd127, 16'hFFFF, 1'b0);
    add_request(OP_INSERT, 7'd0,   16'h0000, 1'b0);
    add_request(OP_INSERT, 7'd1,   16'hA5A5, 1'b0);
    add_request(OP_INSERT, 7'd3,   16'h5A5A, 1'b0);
    add_request(OP_INSERT, 7'd100, 16'h1234, 1'b0);
    add_request(OP_READ,   7'd0,   16'h0000, 1'b0);
    add_request(OP_READ,   7'd4,   16'h0000, 1'b0);
    add_request(OP_READ,   7'd5,   16'h0000, 1'b0);
    add_request(OP_READ,   7'd127, 16'hFFFF, 1'b0);
    add_request(OP_UNUSED, 7'd127, 16'hFFFF, 1'b0);
    // Remove back, front, middle, then one past the end.
    add_request(OP_REMOVE, 7'd4,   16'h0000, 1'b0);
    add_request(OP_REMOVE, 7'd0,   16'h0000, 1'b0);
    add_request(OP_REMOVE, 7'd1,   16'h0000, 1'b0);
    add_request(OP_REMOVE, 7'd2,   16'h0000, 1'b0);
    add_request(OP_READ,   7'd1,   16'h0000, 1'b0);
    add_request(OP_READ,   7'd0,   16'h0000, 1'b0);
    add_request(OP_REMOVE, 7'd1,   16'h0000, 1'b0);
    add_request(OP_REMOVE, 7'd0,   16'h0000, 1'b0);
    add_request(OP_REMOVE, 7'd0,   16'h0000, 1'b0);

    // Fill to full after the pipeline drains, then push past it.
    random_count = 0;
    add_random(85, 5, 1'b1);
    random_count++;
    while (gen_count < LIST_DEPTH) begin
      add_random(85, 5, 1'b0);
      random_count++;
    end
    repeat (8) begin
      add_random(70, 0, 1'b0);
      random_count++;
    end

    // Grow, shrink and mixed phases.
    while (random_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 2);
      phase_len = $urandom_range(15, 50);
      repeat (phase_len) begin
        case (kind)
          0: add_random(75, 10, ($urandom_range(0, 79) == 0));
          1: add_random(10, 70, ($urandom_range(0, 79) == 0));
          default: add_random(35, 30, ($urandom_range(0, 79) == 0));
        endcase
        random_count++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (pending_requests.size() != 0 || in_valid_i);
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
